// ===== hdl/lcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Lidar camera fusion package
// Shared types, widths and constants of the obstacle fusion block.
// ----------------------------------------------------------------------------
package lcf_pkg;

  localparam int RAY_IDX_W  = 12;
  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int ANG_W      = 29;
  localparam int SUM_W      = 24;
  localparam int CNT_W      = 17;
  localparam int SUB_SHIFT  = 3;

  localparam logic [RAY_IDX_W-1:0] RAY_MAX = '1;
  localparam logic [POS_W-1:0]     POS_MAX = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX = '1;
  localparam logic [CNT_W-1:0]     CNT_MAX = '1;

  localparam logic [1:0] KIND_RAY   = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [2:0] REG_SECTOR_HALF   = 3'd0;
  localparam logic [2:0] REG_OBSTACLE_MM   = 3'd1;
  localparam logic [2:0] REG_CAM_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_START_ANGLE   = 3'd3;
  localparam logic [2:0] REG_ANGLE_STEP    = 3'd4;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd5;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd6;

  localparam logic [15:0] CONF_OBSTACLE = 16'd42598;
  localparam logic [15:0] AGE_STALE     = 16'hFFFF;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam int DIV_STEPS = 24;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [14:0]        sector_half_angle;
    logic [15:0]        obstacle_range_mm;
    logic [15:0]        camera_timeout_ticks;
    logic signed [15:0] scan_start_angle;
    logic signed [15:0] scan_angle_step;
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   last;
    logic                   sample;
    logic [7:0]             pixel;
    logic                   range_valid;
    logic [15:0]            range_mm;
    logic signed [ANG_W-1:0] angle;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_ctl_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] quot;
  } div_stat_t;

endpackage

// ===== hdl/lidar_camera_obstacle_fusion.sv =====
// ----------------------------------------------------------------------------
// Lidar camera obstacle fusion
// Finds the closest lidar return in the front sector, scores image brightness
// over a subsampled central window, and reports obstacle, range and confidence.
// ----------------------------------------------------------------------------
//  Channel  Direction  Accepted when           Carries
//  s_*      in         s_tvalid & s_tready     ray, pixel or tick item
//  m_*      out        m_tvalid & m_tready     one fused result per scan
//  cfg_*    in         cfg_valid & cfg_ready   register index and value
//
//  The front accepts one item per cycle while the two-entry queue has room,
//  and the back executes one queued command per cycle unless it stalls.
//  A frame-ending pixel with samples and a nonzero image size starts dividing
//  the brightness sum; the next frame or scan end waits in the queue meanwhile.
//  A scan end also waits while the previous result has not been transferred.
//  rst resets all control state and loads default register values at once.
// ----------------------------------------------------------------------------
module lidar_camera_obstacle_fusion (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // range_mm[15:0], pixel_value[23:16]
  input  logic [2:0]  s_tuser,   // mode[1:0], range_valid[2]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // closest_range_mm[15:0], confidence[31:16]
  output logic [0:0]  m_tuser,   // obstacle_present[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lcf_pkg::cfg_t      cfg;
  lcf_pkg::cmd_t      push_cmd;
  lcf_pkg::cmd_t      head_cmd;
  lcf_pkg::div_ctl_t  div_ctl;
  lcf_pkg::div_stat_t div_stat;
  logic               push;
  logic               q_full;
  logic               pop;
  logic               head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sector_half_angle    <= 15'd1843;
      cfg.obstacle_range_mm    <= 16'd2000;
      cfg.camera_timeout_ticks <= 16'd500;
      cfg.scan_start_angle     <= -16'sd12868;
      cfg.scan_angle_step      <= 16'sd18;
      cfg.image_width          <= 13'd640;
      cfg.image_height         <= 13'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lcf_pkg::REG_SECTOR_HALF:  cfg.sector_half_angle    <= cfg_data[14:0];
        lcf_pkg::REG_OBSTACLE_MM:  cfg.obstacle_range_mm    <= cfg_data;
        lcf_pkg::REG_CAM_TIMEOUT:  cfg.camera_timeout_ticks <= cfg_data;
        lcf_pkg::REG_START_ANGLE:  cfg.scan_start_angle     <= cfg_data;
        lcf_pkg::REG_ANGLE_STEP:   cfg.scan_angle_step      <= cfg_data;
        lcf_pkg::REG_IMAGE_WIDTH:  cfg.image_width          <= cfg_data[12:0];
        lcf_pkg::REG_IMAGE_HEIGHT: cfg.image_height         <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  lcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lcf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .stat (div_stat)
  );

  lcf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .div_ctl    (div_ctl),
    .div_stat   (div_stat),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

// ===== hdl/lcf_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out buffer between the front and the back part.
// ----------------------------------------------------------------------------
module lcf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lcf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lcf_pkg::cmd_t head_cmd
);

  lcf_pkg::cmd_t                  entries [lcf_pkg::Q_DEPTH];
  logic [lcf_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [lcf_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [lcf_pkg::Q_CNT_W-1:0]    count;

  assign full       = count == lcf_pkg::Q_CNT_W'(lcf_pkg::Q_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/lcf_front.sv =====
// ----------------------------------------------------------------------------
// Front part
// Accepts input items, tracks ray index and raster position, and turns each ray,
// pixel or tick item into a command for the back part; other kinds are dropped.
// ----------------------------------------------------------------------------
module lcf_front (
  input  logic          clk,
  input  logic          rst,
  input  lcf_pkg::cfg_t cfg,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,
  input  logic [2:0]    s_tuser,
  input  logic          s_tlast,
  input  logic          q_full,
  output logic          push,
  output lcf_pkg::cmd_t push_cmd
);

  logic [lcf_pkg::RAY_IDX_W-1:0]    ray_index;
  logic [lcf_pkg::POS_W-1:0]        column;
  logic [lcf_pkg::POS_W-1:0]        row;
  logic                             accept;
  logic [1:0]                       mode;
  logic signed [lcf_pkg::ANG_W-1:0] ang_prod;
  logic signed [lcf_pkg::ANG_W-1:0] ang;
  logic [lcf_pkg::DIM_W-1:0]        col_x;
  logic [lcf_pkg::DIM_W-1:0]        row_x;
  logic [lcf_pkg::DIM_W-1:0]        w_lo;
  logic [lcf_pkg::DIM_W-1:0]        w_hi;
  logic [lcf_pkg::DIM_W-1:0]        h_lo;
  logic [lcf_pkg::DIM_W-1:0]        h_hi;
  logic [lcf_pkg::DIM_W+1:0]        w_tri;
  logic [lcf_pkg::DIM_W+1:0]        h_tri;
  logic [lcf_pkg::DIM_W-1:0]        col_off;
  logic [lcf_pkg::DIM_W-1:0]        row_off;
  logic                             col_in;
  logic                             row_in;
  logic                             wrap;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign mode     = s_tuser[1:0];

  assign ang_prod = $signed({1'b0, ray_index}) * $signed(cfg.scan_angle_step);
  assign ang      = ang_prod + {{(lcf_pkg::ANG_W - 16){cfg.scan_start_angle[15]}},
                                cfg.scan_start_angle};

  assign col_x   = {1'b0, column};
  assign row_x   = {1'b0, row};
  assign w_lo    = {2'b00, cfg.image_width[lcf_pkg::DIM_W-1:2]};
  assign h_lo    = {2'b00, cfg.image_height[lcf_pkg::DIM_W-1:2]};
  assign w_tri   = {2'b00, cfg.image_width} + {1'b0, cfg.image_width, 1'b0};
  assign h_tri   = {2'b00, cfg.image_height} + {1'b0, cfg.image_height, 1'b0};
  assign w_hi    = w_tri[lcf_pkg::DIM_W+1:2];
  assign h_hi    = h_tri[lcf_pkg::DIM_W+1:2];
  assign col_off = col_x - w_lo;
  assign row_off = row_x - h_lo;
  assign col_in  = col_x >= w_lo && col_x < w_hi && col_off[lcf_pkg::SUB_SHIFT-1:0] == '0;
  assign row_in  = row_x >= h_lo && row_x < h_hi && row_off[lcf_pkg::SUB_SHIFT-1:0] == '0;
  assign wrap    = (col_x + lcf_pkg::DIM_W'(1)) >= cfg.image_width || column == lcf_pkg::POS_MAX;

  always_comb begin
    push                 = accept && (mode == lcf_pkg::KIND_RAY || mode == lcf_pkg::KIND_PIXEL ||
                                      mode == lcf_pkg::KIND_TICK);
    push_cmd.kind        = mode;
    push_cmd.last        = s_tlast;
    push_cmd.sample      = col_in && row_in;
    push_cmd.pixel       = s_tdata[23:16];
    push_cmd.range_valid = s_tuser[2];
    push_cmd.range_mm    = s_tdata[15:0];
    push_cmd.angle       = ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ray_index <= '0;
      column    <= '0;
      row       <= '0;
    end else if (accept) begin
      if (mode == lcf_pkg::KIND_RAY) begin
        if (s_tlast) begin
          ray_index <= '0;
        end else if (ray_index != lcf_pkg::RAY_MAX) begin
          ray_index <= ray_index + 1'b1;
        end
      end else if (mode == lcf_pkg::KIND_PIXEL) begin
        if (s_tlast) begin
          column <= '0;
          row    <= '0;
        end else if (wrap) begin
          column <= '0;
          if (row != lcf_pkg::POS_MAX) begin
            row <= row + 1'b1;
          end
        end else begin
          column <= column + 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/lcf_div.sv =====
// ----------------------------------------------------------------------------
// Score divider
// Restoring divider that takes the brightness sum over the sample count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcf_div (
  input  logic               clk,
  input  logic               rst,
  input  lcf_pkg::div_ctl_t  ctl,
  output lcf_pkg::div_stat_t stat
);

  logic                            busy;
  logic [lcf_pkg::DIV_CNT_W-1:0]   step;
  logic [lcf_pkg::SUM_W-1:0]       nq;
  logic [lcf_pkg::CNT_W-1:0]       rem;
  logic [lcf_pkg::CNT_W-1:0]       den;
  logic [lcf_pkg::CNT_W:0]         rem_sh;
  logic [lcf_pkg::CNT_W+1:0]       diff;
  logic                            ge;

  assign rem_sh = {rem, nq[lcf_pkg::SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};
  assign ge     = !diff[lcf_pkg::CNT_W+1];

  always_comb begin
    stat.busy = busy;
    stat.done = busy && step == lcf_pkg::DIV_CNT_W'(lcf_pkg::DIV_STEPS - 1);
    stat.quot = {nq[6:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nq  <= ctl.num;
      den <= ctl.den;
      rem <= '0;
    end else if (busy) begin
      nq  <= {nq[lcf_pkg::SUM_W-2:0], ge};
      rem <= ge ? diff[lcf_pkg::CNT_W-1:0] : rem_sh[lcf_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (stat.done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/lcf_back.sv =====
// ----------------------------------------------------------------------------
// Back part
// Executes queued commands: closest range search, brightness accumulation,
// score age, and the fused result at scan end.
// ----------------------------------------------------------------------------
module lcf_back (
  input  logic               clk,
  input  logic               rst,
  input  lcf_pkg::cfg_t      cfg,
  input  logic               head_valid,
  input  lcf_pkg::cmd_t      head_cmd,
  output logic               pop,
  output lcf_pkg::div_ctl_t  div_ctl,
  input  lcf_pkg::div_stat_t div_stat,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata,
  output logic [0:0]         m_tuser
);

  logic [15:0]               closest;
  logic [lcf_pkg::SUM_W-1:0] sum;
  logic [lcf_pkg::CNT_W-1:0] count;
  logic [14:0]               cam_term;
  logic [15:0]               age;
  logic [15:0]               out_closest;
  logic [15:0]               out_conf;
  logic                      out_obst;

  logic                      is_ray;
  logic                      is_pixel;
  logic                      is_tick;
  logic                      out_free;
  logic                      stall;
  logic [lcf_pkg::ANG_W-2:0] mag;
  logic                      hit;
  logic [15:0]               closest_next;
  logic [lcf_pkg::SUM_W:0]   sum_add;
  logic [lcf_pkg::SUM_W-1:0] sum_next;
  logic [lcf_pkg::CNT_W-1:0] count_next;
  logic                      dims_ok;
  logic                      obst;
  logic                      fresh;
  logic [15:0]               conf;
  logic [15:0]               frac_y;
  logic [16:0]               frac_q;
  logic [14:0]               cam_next;

  assign is_ray   = head_cmd.kind == lcf_pkg::KIND_RAY;
  assign is_pixel = head_cmd.kind == lcf_pkg::KIND_PIXEL;
  assign is_tick  = head_cmd.kind == lcf_pkg::KIND_TICK;
  assign out_free = !m_tvalid || m_tready;
  assign stall    = head_cmd.last && ((is_pixel && div_stat.busy) ||
                                      (is_ray && (div_stat.busy || !out_free)));
  assign pop      = head_valid && !stall;

  assign mag = head_cmd.angle[lcf_pkg::ANG_W-1] ?
               (lcf_pkg::ANG_W-1)'(-head_cmd.angle) : head_cmd.angle[lcf_pkg::ANG_W-2:0];
  assign hit = head_cmd.range_valid && head_cmd.range_mm < closest &&
               mag <= {{(lcf_pkg::ANG_W - 16){1'b0}}, cfg.sector_half_angle};
  assign closest_next = hit ? head_cmd.range_mm : closest;

  assign sum_add    = {1'b0, sum} + {{(lcf_pkg::SUM_W - 7){1'b0}}, head_cmd.pixel};
  assign sum_next   = !head_cmd.sample ? sum :
                      (sum_add[lcf_pkg::SUM_W] ? lcf_pkg::SUM_MAX : sum_add[lcf_pkg::SUM_W-1:0]);
  assign count_next = (!head_cmd.sample || count == lcf_pkg::CNT_MAX) ? count : count + 1'b1;
  assign dims_ok    = cfg.image_width != '0 && cfg.image_height != '0;

  assign obst  = closest_next < cfg.obstacle_range_mm;
  assign fresh = age != lcf_pkg::AGE_STALE && age <= cfg.camera_timeout_ticks;
  assign conf  = (obst ? lcf_pkg::CONF_OBSTACLE : 16'd0) + (fresh ? {1'b0, cam_term} : 16'd0);

  // 22937 = 89 * 255 + 242, so the camera term is 89 * q + floor(242 * q / 255).
  assign frac_y   = 16'(div_stat.quot) * 16'd242;
  assign frac_q   = ({1'b0, frac_y} + {9'd0, frac_y[15:8]} + 17'd1) >> 8;
  assign cam_next = 15'(16'(div_stat.quot) * 16'd89) + frac_q[14:0];

  always_comb begin
    div_ctl.start = pop && is_pixel && head_cmd.last && dims_ok && count_next != '0;
    div_ctl.num   = sum_next;
    div_ctl.den   = count_next;
  end

  assign m_tdata = {out_conf, out_closest};
  assign m_tuser = out_obst;

  always_ff @(posedge clk) begin
    if (pop && is_ray && head_cmd.last) begin
      out_obst    <= obst;
      out_closest <= closest_next;
      out_conf    <= conf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      closest  <= '1;
      sum      <= '0;
      count    <= '0;
      cam_term <= '0;
      age      <= lcf_pkg::AGE_STALE;
    end else begin
      if (pop && is_ray && head_cmd.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (div_stat.done) begin
        cam_term <= cam_next;
      end
      if (pop) begin
        if (is_ray) begin
          if (head_cmd.last) begin
            closest <= '1;
          end else begin
            closest <= closest_next;
          end
        end else if (is_pixel) begin
          if (head_cmd.last) begin
            sum   <= '0;
            count <= '0;
            if (dims_ok) begin
              age <= '0;
              if (count_next == '0) begin
                cam_term <= '0;
              end
            end
          end else begin
            sum   <= sum_next;
            count <= count_next;
          end
        end else if (is_tick) begin
          if (age != lcf_pkg::AGE_STALE) begin
            age <= age + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/lidar_camera_obstacle_fusion_tb.sv =====
// ----------------------------------------------------------------------------
// Lidar camera obstacle fusion testbench
// Drives ray, pixel, tick and unused-kind items with random pacing and random
// stalls on the result side. A behavioral predictor in the bench tracks the
// scan, raster and camera score state and queues the expected fused result of
// every scan. Each result transfer is compared field by field with the oldest
// expected result. Directed tests cover reset behavior, register extremes,
// camera freshness, empty image size and back pressure. Random phases with
// varying register settings follow.
// ----------------------------------------------------------------------------
module lidar_camera_obstacle_fusion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcf_pkg::*;

  localparam int         SETTLE_CYC  = 64;
  localparam int         PHASES      = 8;
  localparam int         PHASE_ITEMS = 220;
  localparam int         CAM_WEIGHT  = 22937;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] range_mm;
    logic        range_valid;
    logic [7:0]  pixel;
    logic        last;
  } sensor_item_t;

  typedef struct {
    logic        obstacle;
    logic [15:0] closest_mm;
    logic [15:0] confidence;
  } fusion_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  lidar_camera_obstacle_fusion DUT (.*);

  fusion_t pending_fusion[$];
  int      err_cnt = 0;
  bit      tx_steady = 1'b0;
  bit      rx_steady = 1'b0;
  int      rx_hold = 0;

  cfg_t                 shadow_cfg;
  logic [RAY_IDX_W-1:0] ray_idx;
  logic [15:0]          near_mm;
  logic [POS_W-1:0]     pix_col;
  logic [POS_W-1:0]     pix_row;
  logic [SUM_W-1:0]     bright_sum;
  logic [CNT_W-1:0]     bright_cnt;
  logic [7:0]           cam_score;
  logic [15:0]          cam_age;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit in_center(input int pos, input int dim);
    int lo;
    int hi;
    lo = dim / 4;
    hi = (dim * 3) / 4;
    return pos >= lo && pos < hi && ((pos - lo) % (1 << SUB_SHIFT)) == 0;
  endfunction

  function automatic void reset_predictor();
    shadow_cfg.sector_half_angle    = 15'd1843;
    shadow_cfg.obstacle_range_mm    = 16'd2000;
    shadow_cfg.camera_timeout_ticks = 16'd500;
    shadow_cfg.scan_start_angle     = -16'sd12868;
    shadow_cfg.scan_angle_step      = 16'sd18;
    shadow_cfg.image_width          = 13'd640;
    shadow_cfg.image_height         = 13'd480;
    ray_idx    = '0;
    near_mm    = '1;
    pix_col    = '0;
    pix_row    = '0;
    bright_sum = '0;
    bright_cnt = '0;
    cam_score  = '0;
    cam_age    = AGE_STALE;
  endfunction

  task automatic fuse_item(input sensor_item_t it);
    longint  ang;
    int      s;
    int      conf;
    bit      fresh;
    fusion_t res;
    case (it.kind)
      KIND_RAY: begin
        ang = longint'($signed(shadow_cfg.scan_start_angle))
            + longint'(ray_idx) * longint'($signed(shadow_cfg.scan_angle_step));
        if (ang < 0) ang = -ang;
        if (ang <= longint'(shadow_cfg.sector_half_angle) && it.range_valid &&
            it.range_mm < near_mm) near_mm = it.range_mm;
        if (ray_idx != RAY_MAX) ray_idx++;
        if (it.last) begin
          res.obstacle   = near_mm < shadow_cfg.obstacle_range_mm;
          res.closest_mm = near_mm;
          fresh = cam_age != AGE_STALE && cam_age <= shadow_cfg.camera_timeout_ticks;
          conf = res.obstacle ? int'(CONF_OBSTACLE) : 0;
          if (fresh) conf += (CAM_WEIGHT * int'(cam_score)) / 255;
          res.confidence = conf[15:0];
          pending_fusion.insert(pending_fusion.size(), res);
          ray_idx = '0;
          near_mm = '1;
        end
      end
      KIND_PIXEL: begin
        if (in_center(pix_col, shadow_cfg.image_width) &&
            in_center(pix_row, shadow_cfg.image_height)) begin
          s = int'(bright_sum) + int'(it.pixel);
          bright_sum = (s > int'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
          if (bright_cnt != CNT_MAX) bright_cnt++;
        end
        if (int'(pix_col) + 1 >= int'(shadow_cfg.image_width) || pix_col == POS_MAX) begin
          pix_col = '0;
          if (pix_row != POS_MAX) pix_row++;
        end else begin
          pix_col++;
        end
        if (it.last) begin
          if (shadow_cfg.image_width != 0 && shadow_cfg.image_height != 0) begin
            cam_score = (bright_cnt == 0) ? 8'd0 : 8'(bright_sum / bright_cnt);
            cam_age   = '0;
          end
          bright_sum = '0;
          bright_cnt = '0;
          pix_col    = '0;
          pix_row    = '0;
        end
      end
      KIND_TICK: begin
        if (cam_age != AGE_STALE) cam_age++;
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_range();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom);
    if (r < 6) return 16'(int'(shadow_cfg.obstacle_range_mm) + int'($urandom_range(0, 100)) - 50);
    if (r < 8) return 16'($urandom_range(0, 3000));
    if (r == 8) return 16'hFFFF;
    return 16'd0;
  endfunction

  function automatic sensor_item_t mk_ray(input logic [15:0] r, input logic v, input logic l);
    sensor_item_t it;
    it.kind        = KIND_RAY;
    it.range_mm    = r;
    it.range_valid = v;
    it.pixel       = 8'($urandom);
    it.last        = l;
    return it;
  endfunction

  function automatic sensor_item_t mk_pixel(input logic [7:0] p, input logic l);
    sensor_item_t it;
    it.kind        = KIND_PIXEL;
    it.range_mm    = 16'($urandom);
    it.range_valid = 1'($urandom);
    it.pixel       = p;
    it.last        = l;
    return it;
  endfunction

  function automatic sensor_item_t mk_tick(input logic l);
    sensor_item_t it;
    it.kind        = KIND_TICK;
    it.range_mm    = 16'($urandom);
    it.range_valid = 1'($urandom);
    it.pixel       = 8'($urandom);
    it.last        = l;
    return it;
  endfunction

  function automatic int pick_cfg(input int lo, input int hi, input int tlo, input int thi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return tlo + int'($urandom_range(0, thi - tlo));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return DIM_W'($urandom_range(1, 12));
    if (r < 95) return DIM_W'(4096);
    return DIM_W'($urandom_range(1, 4096));
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.sector_half_angle    = 15'(pick_cfg(0, 32767, 0, 4000));
    c.obstacle_range_mm    = 16'(pick_cfg(0, 65535, 0, 20000));
    c.camera_timeout_ticks = 16'(pick_cfg(0, 65534, 0, 40));
    c.scan_start_angle     = 16'(pick_cfg(-32768, 32767, -3000, 3000));
    c.scan_angle_step      = 16'(pick_cfg(-32768, 32767, -300, 300));
    c.image_width          = pick_dim();
    c.image_height         = pick_dim();
    return c;
  endfunction

  task automatic send_item(input sensor_item_t it);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.pixel, it.range_mm};
    s_tuser  <= {it.range_valid, it.kind};
    s_tlast  <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fuse_item(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SECTOR_HALF:  shadow_cfg.sector_half_angle    = val[14:0];
      REG_OBSTACLE_MM:  shadow_cfg.obstacle_range_mm    = val;
      REG_CAM_TIMEOUT:  shadow_cfg.camera_timeout_ticks = val;
      REG_START_ANGLE:  shadow_cfg.scan_start_angle     = val;
      REG_ANGLE_STEP:   shadow_cfg.scan_angle_step      = val;
      REG_IMAGE_WIDTH:  shadow_cfg.image_width          = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT: shadow_cfg.image_height         = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_SECTOR_HALF, {1'b0, c.sector_half_angle});
    write_reg(REG_OBSTACLE_MM, c.obstacle_range_mm);
    write_reg(REG_CAM_TIMEOUT, c.camera_timeout_ticks);
    write_reg(REG_START_ANGLE, c.scan_start_angle);
    write_reg(REG_ANGLE_STEP, c.scan_angle_step);
    write_reg(REG_IMAGE_WIDTH, {3'b000, c.image_width});
    write_reg(REG_IMAGE_HEIGHT, {3'b000, c.image_height});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_fusion.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_item(mk_tick(1'b1));
    send_item(mk_ray(16'd100, 1'b1, 1'b0));
    send_item(mk_ray(16'd0, 1'b1, 1'b1));
    send_item('{KIND_SPARE, 16'hFFFF, 1'b1, 8'hFF, 1'b1});
  endtask

  task automatic test_register_extremes();
    cfg_t c;
    drain_results();
    c.sector_half_angle    = 15'h7FFF;
    c.obstacle_range_mm    = 16'hFFFF;
    c.camera_timeout_ticks = 16'd65534;
    c.scan_start_angle     = 16'sh8000;
    c.scan_angle_step      = 16'sh7FFF;
    c.image_width          = 13'd4096;
    c.image_height         = 13'd4096;
    load_config(c);
    send_item(mk_ray(16'd65534, 1'b1, 1'b0));
    send_item(mk_ray(16'd0, 1'b0, 1'b0));
    send_item(mk_ray(16'd65533, 1'b1, 1'b1));
    send_item(mk_pixel(8'hFF, 1'b0));
    send_item(mk_pixel(8'h00, 1'b1));
    drain_results();
    c.sector_half_angle    = 15'd0;
    c.obstacle_range_mm    = 16'd0;
    c.camera_timeout_ticks = 16'd0;
    c.scan_start_angle     = 16'sh7FFF;
    c.scan_angle_step      = 16'sh8000;
    c.image_width          = 13'd1;
    c.image_height         = 13'd1;
    load_config(c);
    send_item(mk_pixel(8'hFF, 1'b1));
    send_item(mk_ray(16'd0, 1'b1, 1'b0));
    send_item(mk_ray(16'd0, 1'b1, 1'b1));
  endtask

  task automatic test_camera_freshness();
    cfg_t c;
    drain_results();
    c = shadow_cfg;
    c.image_width          = 13'd4;
    c.image_height         = 13'd2;
    c.camera_timeout_ticks = 16'd3;
    c.sector_half_angle    = 15'h7FFF;
    c.scan_start_angle     = 16'sd0;
    c.scan_angle_step      = 16'sd0;
    c.obstacle_range_mm    = 16'hFFFF;
    load_config(c);
    for (int i = 0; i < 8; i++) send_item(mk_pixel((i == 1) ? 8'hFF : 8'($urandom), i == 7));
    send_item(mk_ray(16'd100, 1'b1, 1'b1));
    repeat (3) send_item(mk_tick(1'b0));
    send_item(mk_ray(16'd100, 1'b1, 1'b1));
    send_item(mk_tick(1'b1));
    send_item(mk_ray(16'd100, 1'b1, 1'b1));
    drain_results();
    c.image_width = 13'd0;
    load_config(c);
    send_item(mk_pixel(8'hFF, 1'b0));
    send_item(mk_pixel(8'hFF, 1'b1));
    send_item(mk_ray(16'd0, 1'b1, 1'b1));
  endtask

  task automatic test_backpressure();
    cfg_t c;
    int   n;
    drain_results();
    c = random_config();
    c.sector_half_angle = 15'h7FFF;
    c.scan_start_angle  = 16'sd0;
    c.scan_angle_step   = 16'sd1;
    c.image_width       = 13'd16;
    c.image_height      = 13'd16;
    load_config(c);
    tx_steady = 1'b1;
    rx_hold   = 400;
    wait (rx_hold == 0);
    for (int k = 0; k < 30; k++) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_item(mk_ray(rand_range(), 1'($urandom), i == n - 1));
    end
    tx_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    sensor_item_t it;
    int           sent;
    int           sel;
    int           len;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      load_config(random_config());
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          len = $urandom_range(1, 24);
          for (int i = 0; i < len; i++)
            send_item(mk_ray(rand_range(), $urandom_range(0, 99) < 85, i == len - 1));
          sent += len;
        end else if (sel < 68) begin
          len = int'(shadow_cfg.image_width) * int'(shadow_cfg.image_height);
          if (len > 160 || $urandom_range(0, 9) == 0) len = $urandom_range(1, 160);
          for (int i = 0; i < len; i++) send_item(mk_pixel(8'($urandom), i == len - 1));
          sent += len;
        end else if (sel < 85) begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) send_item(mk_tick(1'($urandom)));
          sent += len;
        end else if (sel < 97) begin
          it.kind        = 2'($urandom);
          it.range_mm    = 16'($urandom);
          it.range_valid = 1'($urandom);
          it.pixel       = 8'($urandom);
          it.last        = 1'($urandom);
          send_item(it);
          if (it.kind != KIND_SPARE) sent++;
        end else begin
          drain_results();
        end
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : rx_pace
    int n;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_steady) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    fusion_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_fusion.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none expected: obstacle %0d closest %0d confidence %0d",
                 $time, m_tuser[0], m_tdata[15:0], m_tdata[31:16]);
      end else begin
        want = pending_fusion.pop_front();
        if (m_tuser[0] !== want.obstacle) begin
          err_cnt++;
          $display("%0t: obstacle_present expected %0d actual %0d",
                   $time, want.obstacle, m_tuser[0]);
        end
        if (m_tdata[15:0] !== want.closest_mm) begin
          err_cnt++;
          $display("%0t: closest_range_mm expected %0d actual %0d",
                   $time, want.closest_mm, m_tdata[15:0]);
        end
        if (m_tdata[31:16] !== want.confidence) begin
          err_cnt++;
          $display("%0t: confidence expected %0d actual %0d",
                   $time, want.confidence, m_tdata[31:16]);
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_extremes();
    test_camera_freshness();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lcf_pkg.sv
hdl/lcf_queue.sv
hdl/lcf_front.sv
hdl/lcf_div.sv
hdl/lcf_back.sv
hdl/lidar_camera_obstacle_fusion.sv
verif/lidar_camera_obstacle_fusion_tb.sv
